@@ rtl/cfwr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfwr_pkg
// Shared constants, codes and types of the CAN firmware image receiver.
// ----------------------------------------------------------------------------
package cfwr_pkg;

	localparam int WORD_BYTES = 32;
	localparam int NBEATS     = (WORD_BYTES + 7) / 8;
	localparam int WORD_W     = NBEATS * 64;
	localparam int BUF_AW     = $clog2(WORD_BYTES);
	localparam int POS_W      = $clog2(WORD_BYTES + 8);
	localparam int SEQ_W      = $clog2(NBEATS + 1);
	localparam int NLANES     = 8;
	localparam int LANE_AW    = 3;
	localparam int ID_W       = 29;
	localparam int CNT_W      = 4;
	localparam int PADDR_W    = 5;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_ERASE   = 2'd1;
	localparam logic [1:0] ACT_PROGRAM = 2'd2;
	localparam logic [1:0] ACT_BOOT    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_NOT_RECV = 2'd2;
	localparam logic [1:0] ST_MISMATCH = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RECV  = 2'd1;
	localparam logic [1:0] PH_ERROR = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	localparam logic [2:0] REG_START_ID = 3'd0;
	localparam logic [2:0] REG_DATA_ID  = 3'd1;
	localparam logic [2:0] REG_END_ID   = 3'd2;
	localparam logic [2:0] REG_SLOT_A   = 3'd3;
	localparam logic [2:0] REG_SLOT_B   = 3'd4;
	localparam logic [2:0] REG_BOOTED   = 3'd5;

	localparam logic [ID_W-1:0] RST_START_ID = 29'd256;
	localparam logic [ID_W-1:0] RST_DATA_ID  = 29'd257;
	localparam logic [ID_W-1:0] RST_END_ID   = 29'd258;
	localparam logic [31:0]     RST_SLOT_A   = 32'h0802_0000;
	localparam logic [31:0]     RST_SLOT_B   = 32'h0810_0000;

	typedef struct packed {
		logic [ID_W-1:0] start_id;
		logic [ID_W-1:0] data_id;
		logic [ID_W-1:0] end_id;
		logic [31:0]     slot_a;
		logic [31:0]     slot_b;
		logic            booted_slot;
	} cfg_t;

	typedef struct packed {
		logic              take;
		logic              in_new;
		logic [BUF_AW-1:0] slot;
		logic [7:0]        data;
	} lane_t;

	typedef struct packed {
		logic              has_word;
		logic              cmd_en;
		logic [1:0]        action;
		logic [31:0]       cmd_addr;
		logic [31:0]       word_addr;
		logic [WORD_W-1:0] word;
		logic [1:0]        status;
		logic [1:0]        phase;
	} job_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] address;
		logic [63:0] beat_data;
		logic [2:0]  beat_index;
		logic [1:0]  status;
		logic [1:0]  phase_now;
		logic        last;
	} result_t;

endpackage

@@ rtl/cfwr_channels.sv @@
// ----------------------------------------------------------------------------
// cfwr channels
// Valid/ready channels for received CAN frames and for flash results.
// ----------------------------------------------------------------------------
interface cfwr_frame_if;
	logic        valid;
	logic        ready;
	logic [28:0] frame_id;
	logic [63:0] payload;
	logic [3:0]  byte_count;

	modport source(output valid, frame_id, payload, byte_count, input ready);
	modport sink(input valid, frame_id, payload, byte_count, output ready);
endinterface

interface cfwr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] address;
	logic [63:0] beat_data;
	logic [2:0]  beat_index;
	logic [1:0]  status;
	logic [1:0]  phase_now;
	logic        last;

	modport source(output valid, action, address, beat_data, beat_index, status,
		phase_now, last, input ready);
	modport sink(input valid, action, address, beat_data, beat_index, status,
		phase_now, last, output ready);
endinterface

@@ rtl/can_firmware_image_receiver_core.sv @@
// ----------------------------------------------------------------------------
// can_firmware_image_receiver_core
// Receives a firmware image over CAN frames and issues flash commands.
// ----------------------------------------------------------------------------
// When a frame is accepted, eight byte lanes place its bytes into the
// word buffer and the update state moves at once. Each frame gives one to
// NBEATS+1 results (a word completed by a data frame gives NBEATS program
// beats; an end frame that flushes a partial word gives NBEATS beats and the
// boot command), sent one per cycle through the output register when the
// result port is ready, which sets the rate: frames with a single result
// flow at one per cycle; with 32-byte words a frame gives five at most.
module can_firmware_image_receiver_core import cfwr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cfwr_frame_if.sink         frame_in,
	cfwr_result_if.source      result_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t    cfg;
	job_t    job;
	logic    in_ready;
	logic    accept;
	result_t res;

	assign frame_in.ready = in_ready;
	assign accept         = frame_in.valid & in_ready;

	cfwr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	cfwr_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.frame_id  (frame_in.frame_id),
		.payload   (frame_in.payload),
		.byte_count(frame_in.byte_count),
		.job       (job)
	);

	cfwr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_in.valid),
		.in_ready (in_ready),
		.job_in   (job),
		.out_valid(result_out.valid),
		.out_ready(result_out.ready),
		.out_res  (res)
	);

	assign result_out.action     = res.action;
	assign result_out.address    = res.address;
	assign result_out.beat_data  = res.beat_data;
	assign result_out.beat_index = res.beat_index;
	assign result_out.status     = res.status;
	assign result_out.phase_now  = res.phase_now;
	assign result_out.last       = res.last;

endmodule

@@ rtl/cfwr_regs.sv @@
// ----------------------------------------------------------------------------
// cfwr_regs
// APB configuration registers: frame identifiers, slot bases, booted slot.
// ----------------------------------------------------------------------------
module cfwr_regs import cfwr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_id    <= RST_START_ID;
			cfg_q.data_id     <= RST_DATA_ID;
			cfg_q.end_id      <= RST_END_ID;
			cfg_q.slot_a      <= RST_SLOT_A;
			cfg_q.slot_b      <= RST_SLOT_B;
			cfg_q.booted_slot <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_ID: cfg_q.start_id    <= pwdata[ID_W-1:0];
				REG_DATA_ID:  cfg_q.data_id     <= pwdata[ID_W-1:0];
				REG_END_ID:   cfg_q.end_id      <= pwdata[ID_W-1:0];
				REG_SLOT_A:   cfg_q.slot_a      <= pwdata;
				REG_SLOT_B:   cfg_q.slot_b      <= pwdata;
				REG_BOOTED:   cfg_q.booted_slot <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_ID: prdata = {3'b000, cfg_q.start_id};
			REG_DATA_ID:  prdata = {3'b000, cfg_q.data_id};
			REG_END_ID:   prdata = {3'b000, cfg_q.end_id};
			REG_SLOT_A:   prdata = cfg_q.slot_a;
			REG_SLOT_B:   prdata = cfg_q.slot_b;
			REG_BOOTED:   prdata = {31'd0, cfg_q.booted_slot};
			default:      prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/cfwr_byte_lane.sv @@
// ----------------------------------------------------------------------------
// cfwr_byte_lane
// One payload byte: decides whether it is taken and where it lands in the
// current word or, past a word boundary, in the next one.
// ----------------------------------------------------------------------------
module cfwr_byte_lane import cfwr_pkg::*; (
	input  logic [LANE_AW-1:0] lane_idx,
	input  logic [7:0]         byte_in,
	input  logic [CNT_W-1:0]   take_count,
	input  logic [BUF_AW-1:0]  fill,
	output lane_t              lane
);

	logic [POS_W-1:0] pos;

	assign pos = POS_W'(fill) + POS_W'(lane_idx);

	always_comb begin
		lane.take   = CNT_W'(lane_idx) < take_count;
		lane.in_new = pos >= POS_W'(WORD_BYTES);
		lane.slot   = lane.in_new ? BUF_AW'(pos - POS_W'(WORD_BYTES)) : BUF_AW'(pos);
		lane.data   = byte_in;
	end

endmodule

@@ rtl/cfwr_update.sv @@
// ----------------------------------------------------------------------------
// cfwr_update
// Frame decode, update state and word assembly. The byte lanes place the
// frame bytes; the merge folds them into the word buffer and builds the job
// of results for the frame.
// ----------------------------------------------------------------------------
module cfwr_update import cfwr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             accept,
	input  logic [ID_W-1:0]  frame_id,
	input  logic [63:0]      payload,
	input  logic [CNT_W-1:0] byte_count,
	output job_t             job
);

	logic [1:0]        phase_q, phase_nxt;
	logic [31:0]       remaining_q, remaining_nxt;
	logic [BUF_AW-1:0] fill_q, fill_nxt;
	logic [31:0]       waddr_q, waddr_nxt;
	logic              target_q, target_nxt;
	logic [7:0]        wbuf_q [WORD_BYTES];
	logic [7:0]        wbuf_nxt [WORD_BYTES];
	logic [7:0]        old_word [WORD_BYTES];
	logic [7:0]        new_buf [WORD_BYTES];
	logic [WORD_W-1:0] old_flat, cur_flat;

	logic [CNT_W-1:0]  n_clamp, rem_clamp, take_count;
	logic [POS_W-1:0]  fill_sum;
	logic              word_done;
	logic              is_start, is_data, is_end;
	lane_t             lanes [NLANES];

	assign n_clamp    = (byte_count > CNT_W'(8)) ? CNT_W'(8) : byte_count;
	assign rem_clamp  = (remaining_q > 32'd8) ? CNT_W'(8) : remaining_q[CNT_W-1:0];
	assign take_count = (n_clamp < rem_clamp) ? n_clamp : rem_clamp;
	assign fill_sum   = POS_W'(fill_q) + POS_W'(take_count);
	assign word_done  = fill_sum >= POS_W'(WORD_BYTES);

	assign is_start = frame_id == cfg.start_id;
	assign is_data  = !is_start && (frame_id == cfg.data_id);
	assign is_end   = !is_start && !is_data && (frame_id == cfg.end_id);

	for (genvar l = 0; l < NLANES; l++) begin : g_lane
		cfwr_byte_lane u_lane (
			.lane_idx  (LANE_AW'(l)),
			.byte_in   (payload[8*l +: 8]),
			.take_count(take_count),
			.fill      (fill_q),
			.lane      (lanes[l])
		);
	end

	// merge: bytes before the boundary finish the current word, the rest
	// start a fresh 0xFF-filled one
	always_comb begin
		for (int e = 0; e < WORD_BYTES; e++) begin
			old_word[e] = wbuf_q[e];
			new_buf[e]  = 8'hFF;
			for (int l = 0; l < NLANES; l++) begin
				if (lanes[l].take && (lanes[l].slot == BUF_AW'(e))) begin
					if (lanes[l].in_new) begin
						new_buf[e] = lanes[l].data;
					end else begin
						old_word[e] = lanes[l].data;
					end
				end
			end
			if (!word_done) begin
				new_buf[e] = old_word[e];
			end
		end
	end

	// beats past the end of the word read as 0xFF
	always_comb begin
		old_flat = '1;
		cur_flat = '1;
		for (int e = 0; e < WORD_BYTES; e++) begin
			old_flat[8*e +: 8] = old_word[e];
			cur_flat[8*e +: 8] = wbuf_q[e];
		end
	end

	always_comb begin
		phase_nxt     = phase_q;
		remaining_nxt = remaining_q;
		fill_nxt      = fill_q;
		waddr_nxt     = waddr_q;
		target_nxt    = target_q;
		for (int e = 0; e < WORD_BYTES; e++) begin
			wbuf_nxt[e] = wbuf_q[e];
		end

		job.has_word  = 1'b0;
		job.cmd_en    = 1'b1;
		job.action    = ACT_NONE;
		job.cmd_addr  = 32'd0;
		job.word_addr = waddr_q;
		job.word      = old_flat;
		job.status    = ST_OK;
		job.phase     = phase_q;

		if (byte_count == '0) begin
			job.status = ST_BAD;
		end else if (is_start) begin
			if (byte_count < CNT_W'(4)) begin
				job.status = ST_BAD;
			end else begin
				remaining_nxt = payload[31:0];
				target_nxt    = ~cfg.booted_slot;
				waddr_nxt     = cfg.booted_slot ? cfg.slot_a : cfg.slot_b;
				fill_nxt      = '0;
				phase_nxt     = PH_RECV;
				for (int e = 0; e < WORD_BYTES; e++) begin
					wbuf_nxt[e] = 8'hFF;
				end
				job.action   = ACT_ERASE;
				job.cmd_addr = waddr_nxt;
				job.phase    = PH_RECV;
			end
		end else if (is_data) begin
			if (phase_q != PH_RECV) begin
				job.status = ST_NOT_RECV;
			end else begin
				remaining_nxt = remaining_q - 32'(take_count);
				for (int e = 0; e < WORD_BYTES; e++) begin
					wbuf_nxt[e] = new_buf[e];
				end
				if (word_done) begin
					job.has_word = 1'b1;
					job.cmd_en   = 1'b0;
					waddr_nxt    = waddr_q + 32'(WORD_BYTES);
					fill_nxt     = BUF_AW'(fill_sum - POS_W'(WORD_BYTES));
				end else begin
					fill_nxt = BUF_AW'(fill_sum);
				end
			end
		end else if (is_end) begin
			if (phase_q != PH_RECV) begin
				job.status = ST_NOT_RECV;
			end else if (remaining_q != 32'd0) begin
				phase_nxt  = PH_ERROR;
				job.status = ST_MISMATCH;
				job.phase  = PH_ERROR;
			end else begin
				phase_nxt    = PH_DONE;
				job.has_word = fill_q != '0;
				job.word     = cur_flat;
				job.action   = ACT_BOOT;
				job.cmd_addr = target_q ? cfg.slot_b : cfg.slot_a;
				job.phase    = PH_DONE;
			end
		end else begin
			job.status = ST_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= 32'd0;
			fill_q      <= '0;
			waddr_q     <= 32'd0;
			target_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_nxt;
			remaining_q <= remaining_nxt;
			fill_q      <= fill_nxt;
			waddr_q     <= waddr_nxt;
			target_q    <= target_nxt;
		end
	end

	// cleared by every start frame of four bytes or more before use
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int e = 0; e < WORD_BYTES; e++) begin
				wbuf_q[e] <= wbuf_nxt[e];
			end
		end
	end

endmodule

@@ rtl/cfwr_emit.sv @@
// ----------------------------------------------------------------------------
// cfwr_emit
// Holds the job of one frame and streams its results, program beats first
// and then the command, into the output register.
// ----------------------------------------------------------------------------
module cfwr_emit import cfwr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  job_t    job_in,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	job_t             job_q;
	logic             job_valid_q;
	logic [SEQ_W-1:0] seq_q;
	logic             out_valid_q;
	result_t          out_q;

	result_t          cur;
	logic             cur_last;
	logic             load;
	logic [63:0]      beat;

	always_comb begin
		beat = 64'd0;
		for (int b = 0; b < NBEATS; b++) begin
			if (seq_q == SEQ_W'(b)) begin
				beat = job_q.word[64*b +: 64];
			end
		end
	end

	always_comb begin
		cur_last = job_q.cmd_en ? (seq_q == SEQ_W'(NBEATS)) : (seq_q == SEQ_W'(NBEATS - 1));
		cur.status    = job_q.status;
		cur.phase_now = job_q.phase;
		cur.last      = cur_last;
		if (seq_q < SEQ_W'(NBEATS)) begin
			cur.action     = ACT_PROGRAM;
			cur.address    = job_q.word_addr;
			cur.beat_data  = beat;
			cur.beat_index = 3'(seq_q);
		end else begin
			cur.action     = job_q.action;
			cur.address    = job_q.cmd_addr;
			cur.beat_data  = 64'd0;
			cur.beat_index = 3'd0;
		end
	end

	assign load     = job_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !job_valid_q || (load && cur_last);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			seq_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				job_valid_q <= 1'b1;
				seq_q       <= job_in.has_word ? SEQ_W'(0) : SEQ_W'(NBEATS);
			end else if (load && cur_last) begin
				job_valid_q <= 1'b0;
			end else if (load) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q <= job_in;
		end
		if (load) begin
			out_q <= cur;
		end
	end

endmodule

@@ sim/cfwr_flash_op_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfwr_flash_op_checker
// Watches the frame, result and register ports of the firmware image
// receiver, predicts the flash operations each accepted frame must produce
// and compares every result transaction against them in order.
// ----------------------------------------------------------------------------
module cfwr_flash_op_checker import cfwr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	cfwr_frame_if              frame_mon,
	cfwr_result_if             result_mon,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 ops_due_count,
	output int                 ops_checked
);

	// shadow of the register file
	logic [ID_W-1:0] start_id_q;
	logic [ID_W-1:0] data_id_q;
	logic [ID_W-1:0] end_id_q;
	logic [31:0]     slot_a_q;
	logic [31:0]     slot_b_q;
	logic            booted_q;

	// update progress
	logic [1:0]  phase_q;
	logic [31:0] total_q;
	logic [31:0] recv_q;
	logic [31:0] waddr_q;
	int unsigned fill_q;
	logic [7:0]  word_q [WORD_BYTES];
	logic        tgt_q;

	result_t frame_ops[$];
	result_t flash_ops_due[$];

	function automatic logic [31:0] base_of(input logic slot);
		return slot ? slot_b_q : slot_a_q;
	endfunction

	function automatic result_t flash_op(input logic [1:0] act, input logic [31:0] addr,
			input logic [63:0] data, input logic [2:0] idx, input logic [1:0] st);
		result_t r;
		r.action     = act;
		r.address    = addr;
		r.beat_data  = data;
		r.beat_index = idx;
		r.status     = st;
		r.phase_now  = phase_q;
		r.last       = 1'b0;
		return r;
	endfunction

	task automatic clear_word();
		foreach (word_q[k])
			word_q[k] = 8'hFF;
	endtask

	// one program beat per eight bytes, short tail padded with erased bytes
	task automatic queue_word();
		logic [63:0] d;
		int p;
		for (int b = 0; b < NBEATS; b++) begin
			d = '0;
			for (int j = 7; j >= 0; j--) begin
				p = b * 8 + j;
				d = {d[55:0], (p < WORD_BYTES) ? word_q[p] : 8'hFF};
			end
			frame_ops.push_back(flash_op(ACT_PROGRAM, waddr_q, d, 3'(b), ST_OK));
		end
	endtask

	task automatic predict_flash_ops(input logic [ID_W-1:0] id, input logic [63:0] pay,
			input logic [CNT_W-1:0] cnt);
		int unsigned n;
		logic [1:0] st;
		result_t r;
		frame_ops.delete();
		st = ST_OK;
		n = (cnt > 8) ? 8 : cnt;
		if (n == 0) begin
			st = ST_BAD;
		end else if (id == start_id_q) begin
			if (n < 4) begin
				st = ST_BAD;
			end else begin
				total_q = pay[31:0];
				tgt_q   = ~booted_q;
				waddr_q = base_of(tgt_q);
				recv_q  = '0;
				fill_q  = 0;
				clear_word();
				phase_q = PH_RECV;
				frame_ops.push_back(flash_op(ACT_ERASE, base_of(tgt_q), '0, '0, ST_OK));
			end
		end else if (id == data_id_q) begin
			if (phase_q != PH_RECV) begin
				st = ST_NOT_RECV;
			end else begin
				// bytes past the announced size are dropped
				for (int i = 0; i < n && recv_q < total_q; i++) begin
					word_q[fill_q] = pay[8*i +: 8];
					fill_q++;
					recv_q++;
					if (fill_q == WORD_BYTES) begin
						queue_word();
						waddr_q += WORD_BYTES;
						fill_q = 0;
						clear_word();
					end
				end
			end
		end else if (id == end_id_q) begin
			if (phase_q != PH_RECV) begin
				st = ST_NOT_RECV;
			end else if (recv_q != total_q) begin
				phase_q = PH_ERROR;
				st = ST_MISMATCH;
			end else begin
				phase_q = PH_DONE;
				if (fill_q > 0)
					queue_word();
				frame_ops.push_back(flash_op(ACT_BOOT, base_of(tgt_q), '0, '0, ST_OK));
			end
		end else begin
			st = ST_BAD;
		end
		if (frame_ops.size() == 0)
			frame_ops.push_back(flash_op(ACT_NONE, '0, '0, '0, st));
		r = frame_ops.pop_back();
		r.last = 1'b1;
		frame_ops.push_back(r);
		foreach (frame_ops[k])
			flash_ops_due.push_back(frame_ops[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			start_id_q = RST_START_ID;
			data_id_q  = RST_DATA_ID;
			end_id_q   = RST_END_ID;
			slot_a_q   = RST_SLOT_A;
			slot_b_q   = RST_SLOT_B;
			booted_q   = 1'b0;
			phase_q    = PH_IDLE;
			total_q    = '0;
			recv_q     = '0;
			waddr_q    = '0;
			fill_q     = 0;
			tgt_q      = 1'b0;
			clear_word();
			flash_ops_due.delete();
			mismatches    = 0;
			ops_due_count = 0;
			ops_checked   = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_START_ID: start_id_q = pwdata[ID_W-1:0];
					REG_DATA_ID:  data_id_q  = pwdata[ID_W-1:0];
					REG_END_ID:   end_id_q   = pwdata[ID_W-1:0];
					REG_SLOT_A:   slot_a_q   = pwdata;
					REG_SLOT_B:   slot_b_q   = pwdata;
					REG_BOOTED:   booted_q   = pwdata[0];
					default: ;
				endcase
			end
			// a frame's results never leave in the cycle it is taken
			if (frame_mon.valid && frame_mon.ready)
				predict_flash_ops(frame_mon.frame_id, frame_mon.payload, frame_mon.byte_count);
			if (result_mon.valid && result_mon.ready) begin
				got.action     = result_mon.action;
				got.address    = result_mon.address;
				got.beat_data  = result_mon.beat_data;
				got.beat_index = result_mon.beat_index;
				got.status     = result_mon.status;
				got.phase_now  = result_mon.phase_now;
				got.last       = result_mon.last;
				ops_checked++;
				if (flash_ops_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result act=%0d addr=%h data=%h beat=%0d st=%0d ph=%0d last=%0d",
							$realtime, got.action, got.address, got.beat_data, got.beat_index,
							got.status, got.phase_now, got.last);
				end else begin
					want = flash_ops_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: result %0d differs", $realtime, ops_checked);
							$display("  expected act=%0d addr=%h data=%h beat=%0d st=%0d ph=%0d last=%0d",
								want.action, want.address, want.beat_data, want.beat_index,
								want.status, want.phase_now, want.last);
							$display("  actual   act=%0d addr=%h data=%h beat=%0d st=%0d ph=%0d last=%0d",
								got.action, got.address, got.beat_data, got.beat_index,
								got.status, got.phase_now, got.last);
						end
					end
				end
			end
			ops_due_count = flash_ops_due.size();
		end
	end

endmodule

@@ sim/tb_can_firmware_image_receiver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_firmware_image_receiver_core
// Drives CAN frames and register writes into the firmware image receiver:
// directed corner frames, then random image transfers with noise frames under
// several register settings, with random stalls on both channels and a long
// output hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_can_firmware_image_receiver_core;
	import cfwr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int flash_mismatches;
	int ops_due;
	int ops_checked;

	bit gaps_on  = 1'b1;
	bit hold_req = 1'b0;
	int frames_sent   = 0;
	int settings_used = 1;
	int cycle_count   = 0;

	logic [ID_W-1:0] cur_start = RST_START_ID;
	logic [ID_W-1:0] cur_data  = RST_DATA_ID;
	logic [ID_W-1:0] cur_end   = RST_END_ID;

	cfwr_frame_if  frame_ch();
	cfwr_result_if result_ch();

	can_firmware_image_receiver_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_in   (frame_ch),
		.result_out (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	cfwr_flash_op_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_mon     (frame_ch),
		.result_mon    (result_ch),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (flash_mismatches),
		.ops_due_count (ops_due),
		.ops_checked   (ops_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, ops_due);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// flash side: random stalls, or one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= !(gaps_on && $urandom_range(99) < 38);
			end
		end
	end

	task automatic send_frame(input logic [ID_W-1:0] id, input logic [63:0] pay,
			input logic [CNT_W-1:0] cnt);
		while (gaps_on && $urandom_range(99) < 38) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.frame_id   <= id;
		frame_ch.payload    <= pay;
		frame_ch.byte_count <= cnt;
		do @(posedge clk); while (!frame_ch.ready);
		frames_sent++;
	endtask

	task automatic drain_results();
		frame_ch.valid <= 1'b0;
		do @(negedge clk); while (ops_due != 0);
		@(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] wval);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= wval;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [ID_W-1:0] s_id, input logic [ID_W-1:0] d_id,
			input logic [ID_W-1:0] e_id, input logic [31:0] base_a, input logic [31:0] base_b,
			input logic boot);
		drain_results();
		repeat (6) @(posedge clk);
		reg_write(REG_START_ID, 32'(s_id));
		reg_write(REG_DATA_ID, 32'(d_id));
		reg_write(REG_END_ID, 32'(e_id));
		reg_write(REG_SLOT_A, base_a);
		reg_write(REG_SLOT_B, base_b);
		reg_write(REG_BOOTED, 32'(boot));
		cur_start = s_id;
		cur_data  = d_id;
		cur_end   = e_id;
		settings_used++;
	endtask

	// start, data until the size is reached, end; with noise and broken transfers
	task automatic image_sequence(input int unsigned size);
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		sent = 0;
		send_frame(cur_start, {$urandom, size},
			($urandom_range(3) == 0) ? 4'($urandom_range(15, 4)) : 4'd8);
		while (sent < size) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_frame(ID_W'($urandom), {$urandom, $urandom}, 4'($urandom_range(15)));
			end else if (pick < 7) begin
				send_frame(cur_data, {$urandom, $urandom}, 4'd0);
			end else if (pick < 9) begin
				break;
			end else begin
				n = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 1);
				send_frame(cur_data, {$urandom, $urandom}, 4'(n));
				sent += (n > 8) ? 8 : n;
			end
		end
		pick = $urandom_range(99);
		if (pick < 10)
			send_frame(cur_data, {$urandom, $urandom}, 4'd8);
		if (pick < 92 || pick >= 96)
			send_frame(cur_end, {$urandom, $urandom}, 4'($urandom_range(8, 1)));
		if (pick >= 96)
			send_frame(cur_data, {$urandom, $urandom}, 4'd8);
	endtask

	task automatic run_images(input int upto);
		while (frames_sent < upto)
			image_sequence(($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(96));
	endtask

	initial begin
		arst_n = 1'b0;
		frame_ch.valid      <= 1'b0;
		frame_ch.frame_id   <= '0;
		frame_ch.payload    <= '0;
		frame_ch.byte_count <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// data and end while idle, bad counts, short start, unknown identifier
		send_frame(RST_DATA_ID, 64'h0123_4567_89AB_CDEF, 4'd8);
		send_frame(RST_END_ID, 64'h0, 4'd1);
		send_frame(RST_START_ID, 64'h0000_0000_0000_0028, 4'd0);
		send_frame(RST_START_ID, 64'h0000_0000_0000_0028, 4'd3);
		send_frame(29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		// 40-byte image: one full word, surplus dropped, partial word flushed at end
		send_frame(RST_START_ID, 64'hFFFF_FFFF_0000_0028, 4'd15);
		send_frame(RST_DATA_ID, 64'h0706_0504_0302_0100, 4'd8);
		send_frame(RST_DATA_ID, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_frame(RST_DATA_ID, 64'h0, 4'd8);
		send_frame(RST_DATA_ID, {$urandom, $urandom}, 4'd8);
		send_frame(RST_DATA_ID, {$urandom, $urandom}, 4'd15);
		send_frame(RST_DATA_ID, {$urandom, $urandom}, 4'd8);
		send_frame(RST_DATA_ID, {$urandom, $urandom}, 4'd0);
		send_frame(RST_END_ID, 64'h0, 4'd8);
		send_frame(RST_END_ID, 64'h0, 4'd8);
		send_frame(RST_DATA_ID, 64'h0, 4'd8);
		// empty image, then a short one ending early
		send_frame(RST_START_ID, 64'h0, 4'd4);
		send_frame(RST_END_ID, 64'h0, 4'd2);
		send_frame(RST_START_ID, 64'h0000_0000_0000_0064, 4'd5);
		send_frame(RST_DATA_ID, 64'h00AA_BBCC, 4'd3);
		send_frame(RST_END_ID, 64'h0, 4'd8);
		send_frame(RST_END_ID, 64'h0, 4'd8);
		// restart from error and restart while receiving
		send_frame(RST_START_ID, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_frame(RST_START_ID, 64'h0000_0000_0000_0020, 4'd4);
		send_frame(29'd0, 64'h0, 4'd1);

		run_images(110);
		hold_req = 1'b1;
		image_sequence(256);
		drain_results();
		run_images(175);

		// address wrap on slot a, booted from b
		set_registers(29'd0, 29'h1FFF_FFFF, 29'h0AAA_AAAA, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b1);
		run_images(285);

		// writes into slot b near the top of the address space, no stalls for a while
		set_registers(29'h1FFF_FFFF, 29'd0, 29'h1555_5555, 32'h0, 32'hFFFF_FFE0, 1'b0);
		gaps_on = 1'b0;
		run_images(345);
		gaps_on = 1'b1;
		run_images(395);

		set_registers(ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), $urandom, $urandom,
			1'($urandom));
		run_images(455);

		// equal identifiers: start takes priority over data, data over end
		set_registers(29'd7, 29'd7, 29'd7, RST_SLOT_A, RST_SLOT_B, 1'b0);
		send_frame(29'd7, 64'h0000_0000_0000_0010, 4'd8);
		send_frame(29'd7, 64'h0000_0000_0000_0010, 4'd2);
		set_registers(29'd7, 29'd9, 29'd9, RST_SLOT_A, RST_SLOT_B, 1'b1);
		send_frame(29'd7, 64'h0000_0000_0000_0008, 4'd4);
		send_frame(29'd9, {$urandom, $urandom}, 4'd8);
		send_frame(29'd9, {$urandom, $urandom}, 4'd8);

		drain_results();
		repeat (10) @(posedge clk);
		$display("%0d frames sent under %0d register settings, incl. a %0d-cycle output hold-off",
			frames_sent, settings_used, HOLD_CYCLES);
		$display("%0d flash results compared, %0d mismatches", ops_checked, flash_mismatches);
		if (flash_mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
